// ===== rtl/scam_pkg.sv =====
// shared types, constants and cordic angle table for the sliding circular angle mean
// no dependencies
`default_nettype none
package scam_pkg;
   localparam int Window     = 16;
   localparam int SlotW      = (Window > 1) ? $clog2(Window) : 1;
   localparam int FillW      = $clog2(Window + 1);
   localparam int SumW       = 17 + $clog2(Window + 1);
   localparam int Steps      = 16;
   localparam int FullTurn   = 46080;
   localparam int QuarterTurn = 11520;
   localparam logic signed [32:0] CordicX0 = 33'sd652032874;
   localparam int Q15Max     = 32767;

   typedef logic signed [15:0] q15_type;

   typedef struct packed {
      q15_type sin_q;
      q15_type cos_q;
   } vec_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [31:0] atan_step(input logic [3:0] i);
      logic signed [31:0] r;
      begin
         unique case (i)
            4'd0: r = 32'sd2949120;  4'd1: r = 32'sd1740967;
            4'd2: r = 32'sd919879;   4'd3: r = 32'sd466945;
            4'd4: r = 32'sd234379;   4'd5: r = 32'sd117304;
            4'd6: r = 32'sd58666;    4'd7: r = 32'sd29335;
            4'd8: r = 32'sd14668;    4'd9: r = 32'sd7334;
            4'd10: r = 32'sd3667;    4'd11: r = 32'sd1833;
            4'd12: r = 32'sd917;     4'd13: r = 32'sd458;
            4'd14: r = 32'sd229;     default: r = 32'sd115;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/scam_rot.sv =====
// rotation cordic pipeline: angle in 1/128 degree to q1.15 unit vector
// depends on scam_pkg
`default_nettype none
module scam_rot
   import scam_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [15:0] angle,
   output vec_type          vec
);
   // stage 0 reduce angle, then 16 cordic stages, then rounding
   logic [1:0]         quad_ff [0:Steps];
   logic signed [33:0] x_ff [0:Steps];
   logic signed [33:0] y_ff [0:Steps];
   logic signed [31:0] z_ff [0:Steps];
   logic [15:0] a_red;
   logic [15:0] a_quarter;
   logic [1:0]  quad_in;

   always_comb begin
      a_red = (angle >= 16'(FullTurn)) ? angle - 16'(FullTurn) : angle;
      if (a_red >= 16'(3 * QuarterTurn)) begin
         quad_in = 2'd3; a_quarter = a_red - 16'(3 * QuarterTurn);
      end else if (a_red >= 16'(2 * QuarterTurn)) begin
         quad_in = 2'd2; a_quarter = a_red - 16'(2 * QuarterTurn);
      end else if (a_red >= 16'(QuarterTurn)) begin
         quad_in = 2'd1; a_quarter = a_red - 16'(QuarterTurn);
      end else begin
         quad_in = 2'd0; a_quarter = a_red;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= quad_in;
         x_ff[0]    <= 34'(CordicX0);
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({7'd0, a_quarter, 9'd0});
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            quad_ff[i+1] <= quad_ff[i];
            if (!z_ff[i][31]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step(4'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step(4'(i));
            end
         end
      end
   end

   function automatic q15_type to_q15(input logic signed [33:0] v);
      logic signed [34:0] r;
      begin
         r = (35'(v) + 35'sd16384) >>> 15;
         if (r > 35'sd32767) return 16'sd32767;
         if (r < -35'sd32767) return -16'sd32767;
         return r[15:0];
      end
   endfunction

   // round and place in quadrant
   q15_type c, s;
   vec_type v_in;
   always_comb begin
      c = to_q15(x_ff[Steps]);
      s = to_q15(y_ff[Steps]);
      case (quad_ff[Steps])
         2'd0: v_in = '{sin_q: s, cos_q: c};
         2'd1: v_in = '{sin_q: c, cos_q: -s};
         2'd2: v_in = '{sin_q: -s, cos_q: -c};
         default: v_in = '{sin_q: -c, cos_q: s};
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) vec <= v_in;
   end
endmodule
`default_nettype wire

// ===== rtl/scam_vec.sv =====
// vectoring cordic pipeline: running sums to angle in 1/128 degree
// depends on scam_pkg
`default_nettype none
module scam_vec
   import scam_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic signed [SumW-1:0] sum_c,
   input  wire logic signed [SumW-1:0] sum_s,
   output logic [15:0]                 angle
);
   localparam int XW = SumW + 11;
   logic               zero_ff [0:Steps];
   logic signed [XW-1:0] x_ff [0:Steps];
   logic signed [XW-1:0] y_ff [0:Steps];
   logic signed [31:0] z_ff [0:Steps];
   logic signed [XW-1:0] xs, ys;

   // scale and fold into the right half plane
   always_comb begin
      xs = XW'(sum_c) <<< 8;
      ys = XW'(sum_s) <<< 8;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (sum_c == '0) && (sum_s == '0);
         if (xs < 0) begin
            x_ff[0] <= -xs; y_ff[0] <= -ys; z_ff[0] <= 32'sd11796480;
         end else begin
            x_ff[0] <= xs; y_ff[0] <= ys; z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step(4'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step(4'(i));
            end
         end
      end
   end

   // round to 1/128 degree and fold into one turn
   logic signed [31:0] zr;
   logic signed [31:0] m;
   always_comb begin
      zr = (z_ff[Steps] + 32'sd256) >>> 9;
      if (zr < 0) m = zr + 32'sd46080;
      else if (zr >= 32'sd46080) m = zr - 32'sd46080;
      else m = zr;
   end

   always_ff @(posedge clock) begin
      if (en) angle <= zero_ff[Steps] ? 16'd0 : m[15:0];
   end
endmodule
`default_nettype wire

// ===== rtl/scam_ring.sv =====
// window ring memory and running sums for one angle
// depends on scam_pkg
`default_nettype none
module scam_ring
   import scam_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   vld,
   input  wire logic [SlotW-1:0]       slot,
   input  wire logic                   full,
   input  wire vec_type                vec,
   output logic signed [SumW-1:0]      sum_c,
   output logic signed [SumW-1:0]      sum_s
);
   // each slot is evicted once per window turn, long after its write when window > 1
   vec_type mem [0:Window-1];
   vec_type old_ff;
   vec_type new_ff;
   logic    vld_ff, full_ff;
   logic signed [SumW-1:0] sum_c_ff, sum_s_ff, sum_c_in, sum_s_in;

   // stage a: read evicted slot, write new vector
   always_ff @(posedge clock) begin
      if (en) begin
         old_ff <= mem[slot];
         new_ff <= vec;
         if (vld) mem[slot] <= vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; full_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld; full_ff <= full;
      end
   end

   // stage b: update sums; a window of one evicts what was just written
   always_comb begin
      sum_c_in = sum_c_ff + SumW'(new_ff.cos_q);
      sum_s_in = sum_s_ff + SumW'(new_ff.sin_q);
      if (full_ff) begin
         sum_c_in = sum_c_in - SumW'(old_ff.cos_q);
         sum_s_in = sum_s_in - SumW'(old_ff.sin_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_c_ff <= '0; sum_s_ff <= '0;
      end else if (en && vld_ff) begin
         sum_c_ff <= sum_c_in; sum_s_ff <= sum_s_in;
      end
   end

   assign sum_c = vld_ff ? sum_c_in : sum_c_ff;
   assign sum_s = vld_ff ? sum_s_in : sum_s_ff;
endmodule
`default_nettype wire

// ===== rtl/sliding_circular_angle_mean.sv =====
// top level of the sliding circular angle mean
// depends on scam_pkg, scam_rot, scam_ring, scam_vec
//
// usage
//   req_ channel carries an azimuth and elevation word (1/128 degree).
//   rsp_ channel returns one word per request: the circular mean of each
//   angle over the last 16 requests (fewer until the window has filled).
//   the path is a single pipeline: rotation cordic (18 stages), ring
//   read-modify-write on the running sums (1 stage, the sums are forwarded
//   combinationally), vectoring cordic (18 stages).
//   throughput is one word per cycle while the receiver takes each word.
//   the whole pipe advances only when its output register is empty or being
//   taken, so a stalled receiver holds every stage and req_ready falls.
//   reset clears the sums, fill count, write slot and all stage valids;
//   the ring memory itself is not cleared, as entries are read only after
//   they have been written.
`default_nettype none
module sliding_circular_angle_mean
   import scam_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_azimuth_deg,
   input  wire logic [15:0] req_elevation_deg,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_azimuth_mean,
   output logic [15:0]      rsp_elevation_mean
);
   localparam int RotLat = Steps + 2;
   localparam int Lat    = RotLat + 1 + Steps + 2;

   logic en;
   logic [Lat-1:0] vld_ff;
   logic [FillW-1:0] fill_ff;
   logic [SlotW-1:0] slot_ff;

   assign en        = !vld_ff[Lat-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[Lat-1];

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], req_valid};
   end

   vec_type az_vec, el_vec;
   scam_rot u_rot_az (.clock, .en, .angle(req_azimuth_deg), .vec(az_vec));
   scam_rot u_rot_el (.clock, .en, .angle(req_elevation_deg), .vec(el_vec));

   // ring slot and fill tracking at ring entry
   logic ring_vld, full;
   assign ring_vld = vld_ff[RotLat-1];
   assign full     = (fill_ff == FillW'(Window));
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0; slot_ff <= '0;
      end else if (en && ring_vld) begin
         if (!full) fill_ff <= fill_ff + 1'b1;
         slot_ff <= (slot_ff == SlotW'(Window - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   logic signed [SumW-1:0] az_c, az_s, el_c, el_s;
   scam_ring u_ring_az (.clock, .reset, .en, .vld(ring_vld), .slot(slot_ff),
      .full, .vec(az_vec), .sum_c(az_c), .sum_s(az_s));
   scam_ring u_ring_el (.clock, .reset, .en, .vld(ring_vld), .slot(slot_ff),
      .full, .vec(el_vec), .sum_c(el_c), .sum_s(el_s));

   scam_vec u_vec_az (.clock, .en, .sum_c(az_c), .sum_s(az_s),
      .angle(rsp_azimuth_mean));
   scam_vec u_vec_el (.clock, .en, .sum_c(el_c), .sum_s(el_s),
      .angle(rsp_elevation_mean));
endmodule
`default_nettype wire
